[sv/rhc_pkg.sv]
// ----------------------------------------------------------------------------
// rhc_pkg
// Widths, constants and shared types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    localparam int CH_W  = 8;    // colour channel width
    localparam int HUE_W = 15;   // hue, degrees times 64
    localparam int SAT_W = 8;

    // Shared restoring divider geometry
    localparam int NUM_W      = 21;
    localparam int DEN_W      = 9;
    localparam int QUO_W      = 12;
    localparam int DIV_STAGES = QUO_W;

    localparam int SUM_W = HUE_W + 1;

    localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(23039);

    // Hue base in degrees times 64, for a non-negative and a negative difference
    localparam logic [HUE_W-1:0] BASE_RED_POS   = HUE_W'(0);
    localparam logic [HUE_W-1:0] BASE_RED_NEG   = HUE_W'(19200);
    localparam logic [HUE_W-1:0] BASE_GREEN_POS = HUE_W'(7680);
    localparam logic [HUE_W-1:0] BASE_GREEN_NEG = HUE_W'(3840);
    localparam logic [HUE_W-1:0] BASE_BLUE_POS  = HUE_W'(15360);
    localparam logic [HUE_W-1:0] BASE_BLUE_NEG  = HUE_W'(11520);

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_max_ch;

    // Data that rides alongside the dividers
    typedef struct packed {
        logic [HUE_W-1:0] base;
        logic [CH_W-1:0]  brightness;
        logic             undefined;
    } t_side;

endpackage

`default_nettype wire

[sv/rhc_if.sv]
// ----------------------------------------------------------------------------
// rhc_if
// Valid/ready channels for RGB pixels in and HSV results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rhc_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [rhc_pkg::CH_W-1:0]  red;
    logic [rhc_pkg::CH_W-1:0]  green;
    logic [rhc_pkg::CH_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
    logic                      valid;
    logic                      ready;
    logic [rhc_pkg::HUE_W-1:0] hue;
    logic [rhc_pkg::SAT_W-1:0] saturation;
    logic [rhc_pkg::CH_W-1:0]  brightness;
    logic                      hue_undefined;

    modport source (output valid, output hue, output saturation, output brightness,
                    output hue_undefined, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input hue_undefined, output ready);
endinterface

`default_nettype wire

[sv/rhc_divider.sv]
// ----------------------------------------------------------------------------
// rhc_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_divider (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [rhc_pkg::NUM_W-1:0]   i_num,
    input  wire logic [rhc_pkg::DEN_W-1:0]   i_den,
    output logic      [rhc_pkg::QUO_W-1:0]   o_quo
);

    // Quotient is known to fit in QUO_W bits, so the top of the numerator
    // is already below the divisor and seeds the partial remainder.
    logic [rhc_pkg::DEN_W-1:0] r_rem [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::QUO_W-1:0] r_low [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::QUO_W-1:0] r_quo [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::DEN_W-1:0] r_den [rhc_pkg::DIV_STAGES];

    logic [rhc_pkg::DEN_W-1:0] s_rem [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::QUO_W-1:0] s_low [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::QUO_W-1:0] s_quo [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::DEN_W-1:0] s_den [rhc_pkg::DIV_STAGES];

    logic [rhc_pkg::DEN_W-1:0] n_rem [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::QUO_W-1:0] n_low [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::QUO_W-1:0] n_quo [rhc_pkg::DIV_STAGES];

    always_comb begin
        s_rem[0] = i_num[rhc_pkg::NUM_W-1:rhc_pkg::QUO_W];
        s_low[0] = i_num[rhc_pkg::QUO_W-1:0];
        s_quo[0] = '0;
        s_den[0] = i_den;
        for (int k = 1; k < rhc_pkg::DIV_STAGES; k++) begin
            s_rem[k] = r_rem[k-1];
            s_low[k] = r_low[k-1];
            s_quo[k] = r_quo[k-1];
            s_den[k] = r_den[k-1];
        end
    end

    always_comb begin
        logic [rhc_pkg::DEN_W:0] trial;
        logic                    ge;
        trial = '0;
        ge    = 1'b0;
        for (int k = 0; k < rhc_pkg::DIV_STAGES; k++) begin
            trial    = {s_rem[k], s_low[k][rhc_pkg::QUO_W-1]};
            ge       = (trial >= {1'b0, s_den[k]});
            n_rem[k] = ge ? rhc_pkg::DEN_W'(trial - {1'b0, s_den[k]})
                          : trial[rhc_pkg::DEN_W-1:0];
            n_low[k] = {s_low[k][rhc_pkg::QUO_W-2:0], 1'b0};
            n_quo[k] = {s_quo[k][rhc_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < rhc_pkg::DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quo = r_quo[rhc_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

[sv/rgb_to_hsv_converter.sv]
// Pipeline: 2 front stages, 12 divider stages and 1 output register; the
// dividers give one quotient bit per stage.
// Throughput: one pixel per cycle; the whole pipeline holds while a result
// waits on the output.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts 8-bit RGB pixels to hue (Q9.6 degrees), saturation and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rhc_pixel_if.sink  i_pix,
    rhc_hsv_if.source  o_hsv
);

    logic w_en;

    // ---------------- stage 1: max, min, difference --------------------------
    logic [rhc_pkg::CH_W-1:0] w_max;
    logic [rhc_pkg::CH_W-1:0] w_min;
    logic [rhc_pkg::CH_W:0]   w_diff;
    rhc_pkg::t_max_ch         w_ch;

    logic                     r_s1_valid;
    logic [rhc_pkg::CH_W-1:0] r_s1_max;
    logic [rhc_pkg::CH_W-1:0] r_s1_delta;
    logic [rhc_pkg::CH_W:0]   r_s1_diff;
    rhc_pkg::t_max_ch         r_s1_ch;

    always_comb begin
        w_max = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        w_max = (w_max > i_pix.blue) ? w_max : i_pix.blue;
        w_min = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        w_min = (w_min < i_pix.blue) ? w_min : i_pix.blue;
        // red wins ties, then green
        if (i_pix.red == w_max) begin
            w_ch   = rhc_pkg::CH_RED;
            w_diff = {1'b0, i_pix.green} - {1'b0, i_pix.blue};
        end else if (i_pix.green == w_max) begin
            w_ch   = rhc_pkg::CH_GREEN;
            w_diff = {1'b0, i_pix.blue} - {1'b0, i_pix.red};
        end else begin
            w_ch   = rhc_pkg::CH_BLUE;
            w_diff = {1'b0, i_pix.red} - {1'b0, i_pix.green};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_max   <= w_max;
            r_s1_delta <= w_max - w_min;
            r_s1_diff  <= w_diff;
            r_s1_ch    <= w_ch;
        end
    end

    // ---------------- stage 2: divider operands ------------------------------
    // Negative differences are folded to delta+diff with the base lowered by
    // 60 degrees, so both dividers only see non-negative numerators.
    logic                      w_neg;
    logic [rhc_pkg::CH_W-1:0]  w_x;
    logic [rhc_pkg::CH_W:0]    w_fold;
    logic [rhc_pkg::HUE_W-1:0] w_base;
    logic [11:0]               w_x15;
    rhc_pkg::t_side            w_side;

    logic                      r_s2_valid;
    logic [rhc_pkg::NUM_W-1:0] r_s2_hnum;
    logic [rhc_pkg::NUM_W-1:0] r_s2_snum;
    logic [rhc_pkg::DEN_W-1:0] r_s2_hden;
    logic [rhc_pkg::DEN_W-1:0] r_s2_sden;
    rhc_pkg::t_side            r_s2_side;

    always_comb begin
        w_neg  = r_s1_diff[rhc_pkg::CH_W];
        w_fold = {1'b0, r_s1_delta} + r_s1_diff;
        w_x    = w_neg ? w_fold[rhc_pkg::CH_W-1:0] : r_s1_diff[rhc_pkg::CH_W-1:0];
        w_x15  = {w_x, 4'b0000} - {4'b0000, w_x};
        case (r_s1_ch)
            rhc_pkg::CH_RED:   w_base = w_neg ? rhc_pkg::BASE_RED_NEG   : rhc_pkg::BASE_RED_POS;
            rhc_pkg::CH_GREEN: w_base = w_neg ? rhc_pkg::BASE_GREEN_NEG : rhc_pkg::BASE_GREEN_POS;
            rhc_pkg::CH_BLUE:  w_base = w_neg ? rhc_pkg::BASE_BLUE_NEG  : rhc_pkg::BASE_BLUE_POS;
            default:           w_base = rhc_pkg::BASE_RED_POS;
        endcase
        w_side.base       = w_base;
        w_side.brightness = r_s1_max;
        w_side.undefined  = (r_s1_delta == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // 7680*x + delta, and 510*delta + max
            r_s2_hnum <= {w_x15, 9'b0} | rhc_pkg::NUM_W'(r_s1_delta);
            r_s2_snum <= rhc_pkg::NUM_W'({r_s1_delta, 9'b0})
                         - rhc_pkg::NUM_W'({r_s1_delta, 1'b0})
                         + rhc_pkg::NUM_W'(r_s1_max);
            r_s2_hden <= {r_s1_delta, 1'b0};
            r_s2_sden <= {r_s1_max, 1'b0};
            r_s2_side <= w_side;
        end
    end

    // ---------------- divider stages ----------------------------------------
    logic [rhc_pkg::QUO_W-1:0] w_hquo;
    logic [rhc_pkg::QUO_W-1:0] w_squo;

    rhc_divider u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s2_hnum),
        .i_den (r_s2_hden),
        .o_quo (w_hquo)
    );

    rhc_divider u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s2_snum),
        .i_den (r_s2_sden),
        .o_quo (w_squo)
    );

    logic           r_dv_valid [rhc_pkg::DIV_STAGES];
    rhc_pkg::t_side r_dv_side  [rhc_pkg::DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rhc_pkg::DIV_STAGES; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv_valid[0] <= r_s2_valid;
            for (int k = 1; k < rhc_pkg::DIV_STAGES; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_side[0] <= r_s2_side;
            for (int k = 1; k < rhc_pkg::DIV_STAGES; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // ---------------- output register ---------------------------------------
    rhc_pkg::t_side            w_last;
    logic [rhc_pkg::SUM_W-1:0] w_sum;
    logic [rhc_pkg::HUE_W-1:0] w_hue;
    logic [rhc_pkg::SAT_W-1:0] w_sat;

    logic                      r_out_valid;
    logic [rhc_pkg::HUE_W-1:0] r_out_hue;
    logic [rhc_pkg::SAT_W-1:0] r_out_sat;
    logic [rhc_pkg::CH_W-1:0]  r_out_bright;
    logic                      r_out_undef;

    always_comb begin
        w_last = r_dv_side[rhc_pkg::DIV_STAGES-1];
        w_sum  = rhc_pkg::SUM_W'(w_last.base) + rhc_pkg::SUM_W'(w_hquo);
        if (w_last.undefined) begin
            w_hue = '0;
        end else if (w_sum > rhc_pkg::SUM_W'(rhc_pkg::HUE_MAX)) begin
            w_hue = rhc_pkg::HUE_MAX;
        end else begin
            w_hue = w_sum[rhc_pkg::HUE_W-1:0];
        end
        if (w_last.undefined) begin
            w_sat = '0;
        end else if (|w_squo[rhc_pkg::QUO_W-1:rhc_pkg::SAT_W]) begin
            w_sat = '1;
        end else begin
            w_sat = w_squo[rhc_pkg::SAT_W-1:0];
        end
    end

    // Advance everything when the output slot is empty or being taken
    assign w_en = !r_out_valid || o_hsv.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dv_valid[rhc_pkg::DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hue    <= w_hue;
            r_out_sat    <= w_sat;
            r_out_bright <= w_last.brightness;
            r_out_undef  <= w_last.undefined;
        end
    end

    assign i_pix.ready         = w_en;
    assign o_hsv.valid         = r_out_valid;
    assign o_hsv.hue           = r_out_hue;
    assign o_hsv.saturation    = r_out_sat;
    assign o_hsv.brightness    = r_out_bright;
    assign o_hsv.hue_undefined = r_out_undef;

endmodule

`default_nettype wire

[sv/rhc_checker.sv]
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks on the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [rhc_pkg::HUE_W-1:0] i_hue,
    input wire logic [rhc_pkg::SAT_W-1:0] i_sat,
    input wire logic [rhc_pkg::CH_W-1:0]  i_bright,
    input wire logic                      i_undef
);

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hue)
            && $stable(i_sat) && $stable(i_bright) && $stable(i_undef))
        else $error("result changed while stalled");

    // An empty output slot never blocks the input side
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_undef |-> i_hue == '0 && i_sat == '0)
        else $error("undefined hue with non-zero hue or saturation");

    a_defined_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_undef |-> i_bright != '0 && i_hue <= rhc_pkg::HUE_MAX
            && i_sat != '0)
        else $error("defined hue out of range");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_hsv.valid),
    .i_out_ready (o_hsv.ready),
    .i_hue       (o_hsv.hue),
    .i_sat       (o_hsv.saturation),
    .i_bright    (o_hsv.brightness),
    .i_undef     (o_hsv.hue_undefined)
);

`default_nettype wire
